/* design/mfs_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the max-frequency stack.
// No dependencies; mfs_ctrl, mfs_dp and max_frequency_stack_top import this package.
package mfs_pkg;

  localparam int VALUE_BITS          = 30;
  localparam int STACK_DEPTH_DEF     = 1024;
  localparam int DISTINCT_VALUES_DEF = 256;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] popped_value;
    logic [1:0]            status;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch;
    logic       scan_start;
    logic       scan;
    logic       resolve;
    logic       p_head;
    logic       p_slot;
    logic       p_upd;
    logic       p_cnt;
    logic       u_lvl;
    logic       u_link;
    logic       resp;
    logic [1:0] resp_status;
  } mfs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_done;
    logic entry_ok;
    logic out_busy;
  } mfs_stat_t;

endpackage

/* design/mfs_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* design/mfs_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for push and pop words of the max-frequency stack.
// Depends on mfs_pkg; drives mfs_dp through mfs_cmd_t.
module mfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  input  mfs_pkg::mfs_stat_t stat,
  output mfs_pkg::mfs_cmd_t  cmd
);
  import mfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_RESOLVE, S_U_LVL, S_U_LINK,
    S_P_HEAD, S_P_SLOT, S_P_UPD, S_P_CNT, S_RESP
  } state_t;

  state_t     state_r, state_nxt;
  logic       kind_r, kind_nxt;
  logic [1:0] status_r, status_nxt;

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.resp_status = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          kind_nxt  = in_kind;
          if (in_kind == KIND_POP) begin
            if (stat.empty) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_P_HEAD;
            end
          end else if (stat.full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = (kind_r == KIND_POP) ? S_P_CNT : S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        cmd.resolve = 1'b1;
        if (stat.entry_ok) begin
          state_nxt = S_U_LVL;
        end else begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end
      end
      S_U_LVL: begin
        cmd.u_lvl = 1'b1;
        state_nxt = S_U_LINK;
      end
      S_U_LINK: begin
        cmd.u_link = 1'b1;
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
      end
      S_P_HEAD: begin
        cmd.p_head = 1'b1;
        state_nxt  = S_P_SLOT;
      end
      S_P_SLOT: begin
        cmd.p_slot = 1'b1;
        state_nxt  = S_P_UPD;
      end
      S_P_UPD: begin
        cmd.p_upd      = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = S_SCAN;
      end
      S_P_CNT: begin
        cmd.p_cnt  = 1'b1;
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        cmd.resp = 1'b1;
        if (!stat.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      kind_r   <= KIND_PUSH;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      kind_r   <= kind_nxt;
      status_r <= status_nxt;
    end
  end

endmodule

/* design/mfs_dp.sv */
`timescale 1ns / 1ps
// Datapath: value/count tables, linked level stacks, free list, result register.
// Depends on mfs_pkg and mfs_ram; commanded by mfs_ctrl.
module mfs_dp #(
  parameter int STACK_DEPTH     = mfs_pkg::STACK_DEPTH_DEF,
  parameter int DISTINCT_VALUES = mfs_pkg::DISTINCT_VALUES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mfs_pkg::in_word_t  in_word,
  input  mfs_pkg::mfs_cmd_t  cmd,
  output mfs_pkg::mfs_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output mfs_pkg::out_word_t out_word
);
  import mfs_pkg::*;

  localparam int LW = $clog2(STACK_DEPTH + 1);  // counts, levels, links with end mark
  localparam int SW = $clog2(STACK_DEPTH);      // slot / level index
  localparam int DW = $clog2(DISTINCT_VALUES);  // distinct entry index
  localparam logic [LW-1:0] END_MARK = LW'(STACK_DEPTH);
  localparam logic [DW-1:0] LAST_ENT = DW'(DISTINCT_VALUES - 1);

  // control state
  logic [LW-1:0]          free_r, fresh_r, top_r, elem_r;
  logic [DISTINCT_VALUES-1:0] vld_r;
  logic                   pend_r, hit_r, ufound_r, out_valid_r;
  // payload
  logic [VALUE_BITS-1:0]  val_r, popv_r;
  logic                   kind_r;
  logic [DW-1:0]          iss_r, pidx_r, e_r, u_r;
  logic [LW-1:0]          cnt_r;
  logic [SW-1:0]          head_r;
  out_word_t              out_r;

  // RAM ports
  logic                  dv_we, dc_we, sv_we, sn_we, lh_we;
  logic                  dv_re, dc_re, sv_re, sn_re, lh_re;
  logic [DW-1:0]         dv_wa, dc_wa, dv_ra, dc_ra;
  logic [SW-1:0]         sv_wa, sn_wa, lh_wa, sv_ra, sn_ra, lh_ra;
  logic [VALUE_BITS-1:0] dv_wd, sv_wd, dv_rd, sv_rd;
  logic [LW-1:0]         dc_wd, sn_wd, lh_wd, dc_rd, sn_rd, lh_rd;

  logic [VALUE_BITS-1:0] key;
  logic                  match, unused;
  logic [LW-1:0]         lvl, old_head;
  logic [SW-1:0]         top_idx, new_slot;
  logic                  from_list;

  assign key       = (kind_r == KIND_POP) ? popv_r : val_r;
  assign match     = pend_r && vld_r[pidx_r] && (dv_rd == key);
  assign unused    = pend_r && !vld_r[pidx_r];
  assign lvl       = cnt_r + LW'(1);
  assign top_idx   = top_r[SW-1:0] - SW'(1);
  assign from_list = (free_r != END_MARK);
  assign new_slot  = from_list ? free_r[SW-1:0] : fresh_r[SW-1:0];
  // levels above the top are empty whatever the RAM holds
  assign old_head  = (lvl <= top_r) ? lh_rd : END_MARK;

  always_comb begin
    dv_we = 1'b0; dv_wa = u_r; dv_wd = val_r;
    dv_re = cmd.scan; dv_ra = iss_r;
    dc_re = cmd.scan; dc_ra = iss_r;
    dc_we = cmd.u_lvl | cmd.p_cnt; dc_wa = e_r;
    dc_wd = cmd.u_lvl ? lvl : (cnt_r - LW'(1));
    sv_we = cmd.u_link; sv_wa = new_slot; sv_wd = val_r;
    sv_re = cmd.p_slot; sv_ra = lh_rd[SW-1:0];
    sn_we = cmd.u_link | cmd.p_upd;
    sn_wa = cmd.u_link ? new_slot : head_r;
    sn_wd = cmd.u_link ? old_head : free_r;
    sn_re = cmd.p_slot | cmd.u_lvl;
    sn_ra = cmd.p_slot ? lh_rd[SW-1:0] : free_r[SW-1:0];
    lh_we = cmd.u_link | cmd.p_upd;
    lh_wa = cmd.u_link ? cnt_r[SW-1:0] : top_idx;
    lh_wd = cmd.u_link ? LW'(new_slot) : sn_rd;
    lh_re = cmd.p_head | cmd.u_lvl;
    lh_ra = cmd.p_head ? top_idx : cnt_r[SW-1:0];
    if (cmd.resolve && !hit_r && ufound_r) begin
      dv_we = 1'b1;
    end
  end

  mfs_ram #(.WIDTH(VALUE_BITS), .DEPTH(DISTINCT_VALUES)) u_dval (
    .clk, .wr_en(dv_we), .wr_addr(dv_wa), .wr_data(dv_wd),
    .rd_en(dv_re), .rd_addr(dv_ra), .rd_data(dv_rd));
  mfs_ram #(.WIDTH(LW), .DEPTH(DISTINCT_VALUES)) u_dcnt (
    .clk, .wr_en(dc_we), .wr_addr(dc_wa), .wr_data(dc_wd),
    .rd_en(dc_re), .rd_addr(dc_ra), .rd_data(dc_rd));
  mfs_ram #(.WIDTH(VALUE_BITS), .DEPTH(STACK_DEPTH)) u_sval (
    .clk, .wr_en(sv_we), .wr_addr(sv_wa), .wr_data(sv_wd),
    .rd_en(sv_re), .rd_addr(sv_ra), .rd_data(sv_rd));
  mfs_ram #(.WIDTH(LW), .DEPTH(STACK_DEPTH)) u_snext (
    .clk, .wr_en(sn_we), .wr_addr(sn_wa), .wr_data(sn_wd),
    .rd_en(sn_re), .rd_addr(sn_ra), .rd_data(sn_rd));
  mfs_ram #(.WIDTH(LW), .DEPTH(STACK_DEPTH)) u_lhead (
    .clk, .wr_en(lh_we), .wr_addr(lh_wa), .wr_data(lh_wd),
    .rd_en(lh_re), .rd_addr(lh_ra), .rd_data(lh_rd));

  assign stat.empty     = (elem_r == '0);
  assign stat.full      = (elem_r == END_MARK);
  assign stat.scan_done = match || (pend_r && (pidx_r == LAST_ENT));
  assign stat.entry_ok  = hit_r || ufound_r;
  assign stat.out_busy  = out_valid_r && out_stall;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_word.kind;
      val_r  <= in_word.value;
    end
    if (cmd.scan_start) begin
      iss_r <= '0;
    end else if (cmd.scan) begin
      iss_r  <= iss_r + DW'(1);
      pidx_r <= iss_r;
    end
    if (cmd.scan && match) begin
      e_r   <= pidx_r;
      cnt_r <= dc_rd;
    end
    if (cmd.scan && unused && !ufound_r) begin
      u_r <= pidx_r;
    end
    if (cmd.resolve && !hit_r) begin
      e_r   <= u_r;
      cnt_r <= '0;
    end
    if (cmd.p_slot) begin
      head_r <= lh_rd[SW-1:0];
    end
    if (cmd.p_upd) begin
      popv_r <= sv_rd;
    end
    if (cmd.resp && !stat.out_busy) begin
      out_r.status       <= cmd.resp_status;
      out_r.popped_value <= (kind_r == KIND_POP && cmd.resp_status == ST_OK) ?
                            popv_r : '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= END_MARK;
      fresh_r     <= '0;
      top_r       <= '0;
      elem_r      <= '0;
      vld_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      ufound_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        pend_r   <= 1'b0;
        hit_r    <= 1'b0;
        ufound_r <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= 1'b1;
        if (match) begin
          hit_r <= 1'b1;
        end
        if (unused) begin
          ufound_r <= 1'b1;
        end
      end
      if (cmd.u_lvl) begin
        vld_r[e_r] <= 1'b1;
      end
      if (cmd.p_cnt && cnt_r == LW'(1)) begin
        vld_r[e_r] <= 1'b0;
      end
      if (cmd.u_link) begin
        if (from_list) begin
          free_r <= sn_rd;
        end else begin
          fresh_r <= fresh_r + LW'(1);
        end
        if (lvl > top_r) begin
          top_r <= lvl;
        end
        elem_r <= elem_r + LW'(1);
      end
      if (cmd.p_upd) begin
        free_r <= LW'(head_r);
        elem_r <= elem_r - LW'(1);
        if (sn_rd == END_MARK) begin
          top_r <= top_r - LW'(1);
        end
      end
      if (cmd.resp && !stat.out_busy) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

/* design/max_frequency_stack_top.sv */
`timescale 1ns / 1ps
// Max-frequency stack: push a value, or pop the most frequent one (newest wins ties).
// One result word per input word. Each push or pop looks its value up by a linear
// scan of the distinct-value RAM, one entry per cycle, stopping at the match; that
// scan sets the rate, and a new value scans all entries. A pop on an empty store or
// a push into a full store is refused without a scan; a push of a new value is
// refused for lack of a free table entry only at the end of its scan. A word is
// answered before the next is taken, and the answer waits while the previous result
// stays stalled in the output register. The next word is taken while the previous
// result waits in the output register. No clearing pass.
// Depends on mfs_pkg, mfs_ctrl, mfs_dp, mfs_ram.
module max_frequency_stack_top #(
  parameter int STACK_DEPTH     = mfs_pkg::STACK_DEPTH_DEF,
  parameter int DISTINCT_VALUES = mfs_pkg::DISTINCT_VALUES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mfs_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output mfs_pkg::out_word_t out_word
);
  import mfs_pkg::*;

  mfs_cmd_t  cmd;
  mfs_stat_t stat;

  mfs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_kind(in_word.kind), .in_stall, .stat, .cmd);

  mfs_dp #(.STACK_DEPTH(STACK_DEPTH), .DISTINCT_VALUES(DISTINCT_VALUES)) u_dp (
    .clk, .rst_n, .in_word, .cmd, .stat, .out_valid, .out_stall, .out_word);

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for max_frequency_stack_top: directed and random push/pop words,
// checked against an in-bench model of the frequency stack. Depends on mfs_pkg.
module testbench;
  import mfs_pkg::*;

  localparam int DEPTH    = STACK_DEPTH_DEF;
  localparam int DISTINCT = DISTINCT_VALUES_DEF;
  localparam int END_SLOT = DEPTH;
  localparam int WATCHDOG = 4000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  max_frequency_stack_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // model state
  logic [VALUE_BITS-1:0] tbl_value[DISTINCT];
  int unsigned           tbl_count[DISTINCT];
  logic [VALUE_BITS-1:0] slot_val[DEPTH];
  int unsigned           slot_link[DEPTH];
  int unsigned           lvl_head[DEPTH];
  int unsigned           free_slot, top_lvl, held;

  out_word_t expected_q[$];
  int        errors;
  int        words_sent, pops_ok, pushes_full, pops_empty;
  bit        calm;
  bit        hold_req;
  int        hold_left, burst_left, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int find_value(logic [VALUE_BITS-1:0] v);
    for (int i = 0; i < DISTINCT; i++)
      if (tbl_count[i] != 0 && tbl_value[i] == v) return i;
    return -1;
  endfunction

  function automatic out_word_t freq_stack_step(in_word_t w);
    out_word_t r;
    int e;
    int unsigned lvl, s;
    r = '0;
    r.status = ST_OK;
    if (w.kind == KIND_PUSH) begin
      if (held >= DEPTH || free_slot >= END_SLOT) begin
        r.status = ST_FULL;
        return r;
      end
      e = find_value(w.value);
      if (e < 0) begin
        for (int i = 0; i < DISTINCT; i++)
          if (e < 0 && tbl_count[i] == 0) e = i;
        if (e < 0) begin
          r.status = ST_FULL;
          return r;
        end
        tbl_value[e] = w.value;
      end
      lvl = tbl_count[e] + 1;
      if (lvl > DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      tbl_count[e] = lvl;
      s = free_slot;
      free_slot = slot_link[s];
      slot_val[s] = w.value;
      slot_link[s] = lvl_head[lvl-1];
      lvl_head[lvl-1] = s;
      if (lvl > top_lvl) top_lvl = lvl;
      held++;
    end else begin
      lvl = top_lvl;
      if (held == 0 || lvl == 0 || lvl_head[lvl-1] >= END_SLOT) begin
        r.status = ST_EMPTY;
        return r;
      end
      s = lvl_head[lvl-1];
      r.popped_value = slot_val[s];
      lvl_head[lvl-1] = slot_link[s];
      slot_link[s] = free_slot;
      free_slot = s;
      held--;
      e = find_value(r.popped_value);
      if (e >= 0) tbl_count[e]--;
      if (lvl_head[lvl-1] >= END_SLOT) top_lvl = lvl - 1;
    end
    return r;
  endfunction

  // one word onto the input channel; the model runs when it is taken
  task automatic send_word(logic kind, logic [VALUE_BITS-1:0] value);
    out_word_t r;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{kind: kind, value: value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = freq_stack_step('{kind: kind, value: value});
    expected_q.insert(expected_q.size(), r);
    words_sent++;
    if (r.status == ST_FULL) pushes_full++;
    if (r.status == ST_EMPTY) pops_empty++;
    if (kind == KIND_POP && r.status == ST_OK) pops_ok++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_ops();
    send_word(KIND_POP, '0);
    send_word(KIND_POP, '1);
    send_word(KIND_PUSH, '0);
    send_word(KIND_PUSH, '1);
    send_word(KIND_PUSH, '0);
    send_word(KIND_PUSH, 30'h2AAAAAAA);
    send_word(KIND_PUSH, 30'h15555555);
    send_word(KIND_PUSH, '1);
    repeat (7) send_word(KIND_POP, 30'h15555555);
    // reuse of a released entry by a new value
    send_word(KIND_PUSH, 30'd7);
    send_word(KIND_PUSH, 30'd9);
    send_word(KIND_POP, '0);
    send_word(KIND_PUSH, 30'd11);
    send_word(KIND_POP, '0);
    send_word(KIND_POP, '0);
    send_word(KIND_POP, '0);
  endtask

  // empty the store, fill the value table, then every slot, then pop the top levels
  task automatic test_full_store();
    while (held > 0) send_word(KIND_POP, VALUE_BITS'($urandom));
    for (int i = 0; i < DISTINCT; i++) send_word(KIND_PUSH, VALUE_BITS'(1000 + i));
    send_word(KIND_PUSH, 30'd5);
    send_word(KIND_POP, '0);
    send_word(KIND_PUSH, 30'd6);
    while (held < DEPTH)
      send_word(KIND_PUSH, VALUE_BITS'(1000 + $urandom_range(0, 3)));
    send_word(KIND_PUSH, 30'd1000);
    send_word(KIND_PUSH, 30'd12345);
    calm = 1'b1;
    repeat (60) send_word(KIND_POP, VALUE_BITS'($urandom));
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 24; i++)
      send_word(i % 3 == 2 ? KIND_POP : KIND_PUSH, VALUE_BITS'(i % 5));
    drain_results();
  endtask

  task automatic test_random(int n);
    logic [VALUE_BITS-1:0] v;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) v = VALUE_BITS'($urandom);
      else v = VALUE_BITS'($urandom_range(0, 11));
      if (held > 200) send_word(KIND_POP, v);
      else send_word($urandom_range(0, 99) < 45 ? KIND_POP : KIND_PUSH, v);
    end
  endtask

  // result side: random stall bursts plus the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      burst_left <= 0;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= 400;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (burst_left != 0) begin
      out_stall <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      burst_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("testbench failed");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word %h", out_word);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_word.popped_value !== e.popped_value) begin
            $error("popped_value: expected %h, got %h", e.popped_value, out_word.popped_value);
            errors++;
          end
          if (out_word.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_word.status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < DISTINCT; i++) tbl_count[i] = 0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_link[i] = i + 1;
      lvl_head[i]  = END_SLOT;
    end
    free_slot = 0; top_lvl = 0; held = 0;
    errors = 0; words_sent = 0; pops_ok = 0; pushes_full = 0; pops_empty = 0;
    calm = 1'b0; hold_req = 1'b0; idle_cycles = 0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_backpressure();
    test_random(260);
    test_full_store();
    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d words: %0d good pops, %0d empty pops, %0d refused pushes",
             words_sent, pops_ok, pops_empty, pushes_full);
    $display("table and slot exhaustion, long result hold-off, random stalls on both sides");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
